// File: design/acld_pkg.sv
// Shared types, constants and character helpers for the ASCII command line decoder.
// No dependencies; every other design file but acld_ram imports this package.
package acld_pkg;

    // Default line buffer capacity (one slot is reserved, so DEPTH = capacity - 1).
    localparam int LINE_CAPACITY_DEF = 32;

    // Field widths.
    localparam int CHAR_W    = 8;
    localparam int CMD_W     = 4;
    localparam int TURN_W    = 31;
    localparam int POS_W     = 10;
    localparam int TIMEOUT_W = 16;

    // Working widths of the number parser.
    localparam int INT_W  = 20;   // integer part, at most 1000009
    localparam int FRAC_W = 10;   // fraction part, at most 999
    localparam int MAG_W  = 30;   // integer * 1000 + fraction
    localparam int GVAL_W = 14;   // position * 10 + digit before the range check

    localparam logic [TIMEOUT_W-1:0] IDLE_TIMEOUT_RST = 16'd50;
    localparam logic [TIMEOUT_W-1:0] TICKS_MAX        = 16'hFFFF;

    localparam logic [INT_W-1:0]  INT_LIMIT  = 20'd100000;
    localparam logic [GVAL_W-1:0] POS_LIMIT  = 14'd1000;
    localparam logic [MAG_W-1:0]  MILLI      = 30'd1000;
    localparam logic [FRAC_W-1:0] FRAC_HUND  = 10'd100;
    localparam logic [FRAC_W-1:0] FRAC_TEN   = 10'd10;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_INVALID  = 4'd0;
    localparam logic [CMD_W-1:0] CMD_START    = 4'd1;
    localparam logic [CMD_W-1:0] CMD_STOP     = 4'd2;
    localparam logic [CMD_W-1:0] CMD_HOME     = 4'd3;
    localparam logic [CMD_W-1:0] CMD_CLEAR    = 4'd4;
    localparam logic [CMD_W-1:0] CMD_STATUS   = 4'd5;
    localparam logic [CMD_W-1:0] CMD_ZERO     = 4'd6;
    localparam logic [CMD_W-1:0] CMD_TURN     = 4'd7;
    localparam logic [CMD_W-1:0] CMD_POSITION = 4'd8;

    // Character codes.
    localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_POINT = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CH_LC_C  = 8'h63;
    localparam logic [CHAR_W-1:0] CH_LC_G  = 8'h67;
    localparam logic [CHAR_W-1:0] CH_LC_H  = 8'h68;
    localparam logic [CHAR_W-1:0] CH_LC_P  = 8'h70;
    localparam logic [CHAR_W-1:0] CH_LC_Q  = 8'h71;
    localparam logic [CHAR_W-1:0] CH_LC_S  = 8'h73;
    localparam logic [CHAR_W-1:0] CH_LC_T  = 8'h74;
    localparam logic [CHAR_W-1:0] CH_LC_Z  = 8'h7A;
    localparam logic [CHAR_W-1:0] CASE_BIT = 8'h20;

    // Character stream from the sequencer to the parser.
    typedef struct packed {
        logic              start;
        logic              ch_vld;
        logic [CHAR_W-1:0] ch;
    } acld_feed_t;

    // Result of the parser back to the sequencer.
    typedef struct packed {
        logic                     done;
        logic [CMD_W-1:0]         cmd;
        logic signed [TURN_W-1:0] turn;
        logic [POS_W-1:0]         pos;
    } acld_res_t;

    function automatic logic is_space(input logic [CHAR_W-1:0] c);
        return (c == CH_SPACE) || (c == CH_TAB);
    endfunction

    function automatic logic is_digit(input logic [CHAR_W-1:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    // Folds case and maps a single command letter to its code.
    function automatic logic [CMD_W-1:0] letter_code(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] lc;
        logic [CMD_W-1:0]  code;
        lc = c | CASE_BIT;
        case (lc)
            CH_LC_P: code = CMD_START;
            CH_LC_S: code = CMD_STOP;
            CH_LC_H: code = CMD_HOME;
            CH_LC_C: code = CMD_CLEAR;
            CH_LC_Q: code = CMD_STATUS;
            CH_LC_Z: code = CMD_ZERO;
            default: code = CMD_INVALID;
        endcase
        return code;
    endfunction

endpackage

// File: design/ascii_command_line_decoder_core.sv
// Top level of the ASCII command line decoder: request handling, line buffer
// and decode sequencing. Depends on acld_pkg, acld_ram and acld_parser.
//
// Usage: each input request carries req_type (0 = received byte in rx_byte,
// 1 = one millisecond tick) on a valid/ready channel. A result carries
// cmd_type, turn_target and position_target on a valid/ready channel.
// A command letter as the first byte of a line, or a byte that overflows the
// line buffer, gives its result in the cycle after the request. Other bytes are
// written to the line buffer RAM and give no result. CR, LF or an idle
// timeout (counted in ticks, set by cfg_we/cfg_wdata) ends a pending line;
// the line is then read back one character per cycle through the RAM's read
// port into the parser. The result is valid once the parser is done, and no
// request is taken meanwhile. The RAM read port sets the read-back rate.
// Results sit in an output register; a new request is taken while a result
// waits only if the receiver takes that result in the same cycle, so a
// stalled receiver stops the input side without losing anything.
// Reset clears the line length, the idle counter and the output valid flag and
// sets the timeout to 50 ticks; the RAM needs no clearing.
module ascii_command_line_decoder_core
    import acld_pkg::*;
#(
    parameter int LINE_CAPACITY = LINE_CAPACITY_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic                     req_type,
    input  logic [CHAR_W-1:0]        rx_byte,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [CMD_W-1:0]         cmd_type,
    output logic signed [TURN_W-1:0] turn_target,
    output logic [POS_W-1:0]         position_target,
    input  logic                     cfg_we,
    input  logic [TIMEOUT_W-1:0]     cfg_wdata
);

    localparam int DEPTH  = LINE_CAPACITY - 1;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int LEN_W  = $clog2(LINE_CAPACITY);

    typedef enum logic [1:0] {
        ST_IDLE   = 2'b01,
        ST_DECODE = 2'b10
    } acld_state_t;

    acld_state_t              state_reg, state_next;
    logic [LEN_W-1:0]         len_reg, len_next;
    logic [TIMEOUT_W-1:0]     ticks_reg, ticks_next;
    logic [TIMEOUT_W-1:0]     timeout_reg;
    logic [LEN_W-1:0]         rd_ptr_reg, rd_ptr_next;
    logic [LEN_W-1:0]         q_pos_reg, q_pos_next;
    logic                     q_vld_reg, q_vld_next;
    logic                     out_valid_reg, out_valid_next;
    logic [CMD_W-1:0]         cmd_reg, cmd_next;
    logic signed [TURN_W-1:0] turn_reg, turn_next;
    logic [POS_W-1:0]         pos_reg, pos_next;

    logic                     slot_free;
    logic                     in_fire;
    logic                     ram_we;
    logic                     ram_re;
    logic                     dec_start;
    logic [CHAR_W-1:0]        ram_q;
    logic [TIMEOUT_W-1:0]     ticks_inc;
    acld_feed_t               feed;
    acld_res_t                res;

    assign slot_free = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == ST_IDLE) && slot_free;
    assign in_fire   = in_valid && in_ready;
    assign ticks_inc = (ticks_reg != TICKS_MAX) ? ticks_reg + TIMEOUT_W'(1) : ticks_reg;

    // Line buffer.
    acld_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (DEPTH)
    ) u_line_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (len_reg[ADDR_W-1:0]),
        .wr_data (rx_byte),
        .rd_en   (ram_re),
        .rd_addr (rd_ptr_reg[ADDR_W-1:0]),
        .rd_data (ram_q)
    );

    // Characters past the line length read as end of text.
    assign feed.start  = dec_start;
    assign feed.ch_vld = (state_reg == ST_DECODE) && q_vld_reg;
    assign feed.ch     = (q_pos_reg < len_reg) ? ram_q : CH_NUL;

    acld_parser u_parser (
        .clk   (clk),
        .rst_n (rst_n),
        .feed  (feed),
        .res   (res)
    );

    // Request handling and decode sequencing.
    always_comb
    begin
        logic start;
        logic emit;

        start          = 1'b0;
        emit           = 1'b0;
        state_next     = state_reg;
        len_next       = len_reg;
        ticks_next     = ticks_reg;
        rd_ptr_next    = rd_ptr_reg;
        q_pos_next     = q_pos_reg;
        q_vld_next     = q_vld_reg;
        cmd_next       = cmd_reg;
        turn_next      = turn_reg;
        pos_next       = pos_reg;
        ram_we         = 1'b0;
        ram_re         = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (req_type)
                    begin
                        ticks_next = ticks_inc;
                        if ((len_reg != '0) && (ticks_inc >= timeout_reg))
                        begin
                            start = 1'b1;
                        end
                    end
                    else
                    begin
                        ticks_next = '0;
                        if ((rx_byte == CH_CR) || (rx_byte == CH_LF))
                        begin
                            start = (len_reg != '0);
                        end
                        else if ((len_reg == '0) && (letter_code(rx_byte) != CMD_INVALID))
                        begin
                            emit      = 1'b1;
                            cmd_next  = letter_code(rx_byte);
                            turn_next = '0;
                            pos_next  = '0;
                        end
                        else if (len_reg < LEN_W'(DEPTH))
                        begin
                            ram_we   = 1'b1;
                            len_next = len_reg + LEN_W'(1);
                        end
                        else
                        begin
                            len_next  = '0;
                            emit      = 1'b1;
                            cmd_next  = CMD_INVALID;
                            turn_next = '0;
                            pos_next  = '0;
                        end
                    end
                end
                if (start)
                begin
                    state_next  = ST_DECODE;
                    rd_ptr_next = '0;
                    q_vld_next  = 1'b0;
                end
            end
            ST_DECODE:
            begin
                if (res.done)
                begin
                    if (slot_free)
                    begin
                        emit       = 1'b1;
                        cmd_next   = res.cmd;
                        turn_next  = res.turn;
                        pos_next   = res.pos;
                        len_next   = '0;
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    // Stream the stored line, one read per cycle.
                    ram_re     = 1'b1;
                    q_vld_next = 1'b1;
                    q_pos_next = rd_ptr_reg;
                    if (rd_ptr_reg != len_reg)
                    begin
                        rd_ptr_next = rd_ptr_reg + LEN_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        dec_start = start;

        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            len_reg       <= '0;
            ticks_reg     <= '0;
            timeout_reg   <= IDLE_TIMEOUT_RST;
            q_vld_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            len_reg       <= len_next;
            ticks_reg     <= ticks_next;
            q_vld_reg     <= q_vld_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                timeout_reg <= cfg_wdata;
            end
        end
    end

    // Read pointers and result payload.
    always_ff @(posedge clk)
    begin
        rd_ptr_reg <= rd_ptr_next;
        q_pos_reg  <= q_pos_next;
        cmd_reg    <= cmd_next;
        turn_reg   <= turn_next;
        pos_reg    <= pos_next;
    end

    assign out_valid       = out_valid_reg;
    assign cmd_type        = cmd_reg;
    assign turn_target     = turn_reg;
    assign position_target = pos_reg;

endmodule

// File: design/acld_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
module acld_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 31
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: design/acld_parser.sv
// Character-serial line parser: consumes one stored character per cycle and
// produces the decoded command. Depends on acld_pkg.
module acld_parser
    import acld_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  acld_feed_t feed,
    output acld_res_t  res
);

    typedef enum logic [11:0] {
        PS_LEAD   = 12'b0000_0000_0001,
        PS_LETTER = 12'b0000_0000_0010,
        PS_TLEAD  = 12'b0000_0000_0100,
        PS_TINT   = 12'b0000_0000_1000,
        PS_TFRAC  = 12'b0000_0001_0000,
        PS_TTAIL  = 12'b0000_0010_0000,
        PS_GLEAD  = 12'b0000_0100_0000,
        PS_GDIG   = 12'b0000_1000_0000,
        PS_GTAIL  = 12'b0001_0000_0000,
        PS_MAG    = 12'b0010_0000_0000,
        PS_SIGN   = 12'b0100_0000_0000,
        PS_DONE   = 12'b1000_0000_0000
    } acld_pstate_t;

    acld_pstate_t             state_reg, state_next;
    logic [CMD_W-1:0]         cmd_reg, cmd_next;
    logic signed [TURN_W-1:0] turn_reg, turn_next;
    logic [POS_W-1:0]         pos_reg, pos_next;
    logic                     neg_reg, neg_next;
    logic                     dig_reg, dig_next;
    logic                     point_reg, point_next;
    logic [INT_W-1:0]         int_reg, int_next;
    logic [FRAC_W-1:0]        frac_reg, frac_next;
    logic [1:0]               fcnt_reg, fcnt_next;
    logic [MAG_W-1:0]         mag_reg, mag_next;

    // Next state and accumulators.
    always_comb
    begin
        logic [CHAR_W-1:0]  c;
        logic [3:0]         d;
        logic               sp, dg;
        logic               do_int, do_frac, do_tail, do_gdig, do_gtail;
        logic [INT_W+3:0]   int_wide;
        logic [GVAL_W-1:0]  gv_wide;
        logic [TURN_W-1:0]  mag_ext;

        c        = feed.ch;
        d        = c[3:0];
        sp       = is_space(c);
        dg       = is_digit(c);
        int_wide = (INT_W+4)'(int_reg) * (INT_W+4)'(10) + (INT_W+4)'(d);
        gv_wide  = GVAL_W'(pos_reg) * GVAL_W'(10) + GVAL_W'(d);
        mag_ext  = {1'b0, mag_reg};

        do_int   = ((state_reg == PS_TLEAD) && !sp && (c != CH_MINUS) && (c != CH_PLUS))
                   || (state_reg == PS_TINT);
        do_frac  = (state_reg == PS_TFRAC);
        do_tail  = (do_int && !dg && (c != CH_POINT)) || (do_frac && !dg)
                   || (state_reg == PS_TTAIL);
        do_gdig  = ((state_reg == PS_GLEAD) && !sp) || (state_reg == PS_GDIG);
        do_gtail = (do_gdig && !dg) || (state_reg == PS_GTAIL);

        state_next = state_reg;
        cmd_next   = cmd_reg;
        turn_next  = turn_reg;
        pos_next   = pos_reg;
        neg_next   = neg_reg;
        dig_next   = dig_reg;
        point_next = point_reg;
        int_next   = int_reg;
        frac_next  = frac_reg;
        fcnt_next  = fcnt_reg;
        mag_next   = mag_reg;

        if (feed.start)
        begin
            state_next = PS_LEAD;
            cmd_next   = CMD_INVALID;
            turn_next  = '0;
            pos_next   = '0;
            neg_next   = 1'b0;
            dig_next   = 1'b0;
            point_next = 1'b0;
            int_next   = '0;
            frac_next  = '0;
            fcnt_next  = '0;
        end
        else
        begin
            case (state_reg)
                PS_MAG:
                begin
                    if (point_reg)
                    begin
                        mag_next = MAG_W'(int_reg) * MILLI + MAG_W'(frac_reg);
                    end
                    else
                    begin
                        mag_next = MAG_W'(int_reg);
                    end
                    state_next = PS_SIGN;
                end
                PS_SIGN:
                begin
                    turn_next  = neg_reg ? -$signed(mag_ext) : $signed(mag_ext);
                    cmd_next   = CMD_TURN;
                    state_next = PS_DONE;
                end
                PS_DONE:
                begin
                    state_next = PS_DONE;
                end
                default:
                begin
                    if (feed.ch_vld)
                    begin
                        // Leading blanks, then the command letter.
                        if (state_reg == PS_LEAD)
                        begin
                            if (!sp)
                            begin
                                if (letter_code(c) != CMD_INVALID)
                                begin
                                    cmd_next   = letter_code(c);
                                    state_next = PS_LETTER;
                                end
                                else if ((c | CASE_BIT) == CH_LC_T)
                                begin
                                    state_next = PS_TLEAD;
                                end
                                else if ((c | CASE_BIT) == CH_LC_G)
                                begin
                                    state_next = PS_GLEAD;
                                end
                                else
                                begin
                                    state_next = PS_DONE;
                                end
                            end
                        end

                        // A single letter must end the text.
                        if (state_reg == PS_LETTER)
                        begin
                            if (c != CH_NUL)
                            begin
                                cmd_next = CMD_INVALID;
                            end
                            state_next = PS_DONE;
                        end

                        // Turn value: blanks, optional sign, digits, fraction, blanks.
                        if ((state_reg == PS_TLEAD) && !sp
                            && ((c == CH_MINUS) || (c == CH_PLUS)))
                        begin
                            neg_next   = (c == CH_MINUS);
                            state_next = PS_TINT;
                        end
                        if (do_int && dg)
                        begin
                            dig_next = 1'b1;
                            if (int_reg <= INT_LIMIT)
                            begin
                                int_next = int_wide[INT_W-1:0];
                            end
                            state_next = PS_TINT;
                        end
                        if (do_int && (c == CH_POINT))
                        begin
                            point_next = 1'b1;
                            state_next = PS_TFRAC;
                        end
                        if (do_frac && dg)
                        begin
                            dig_next = 1'b1;
                            case (fcnt_reg)
                                2'd0:    frac_next = frac_reg + FRAC_W'(d) * FRAC_HUND;
                                2'd1:    frac_next = frac_reg + FRAC_W'(d) * FRAC_TEN;
                                2'd2:    frac_next = frac_reg + FRAC_W'(d);
                                default: frac_next = frac_reg;
                            endcase
                            if (fcnt_reg != 2'd3)
                            begin
                                fcnt_next = fcnt_reg + 2'd1;
                            end
                        end
                        if (do_tail)
                        begin
                            if (sp)
                            begin
                                state_next = PS_TTAIL;
                            end
                            else if ((c == CH_NUL) && dig_reg)
                            begin
                                state_next = PS_MAG;
                            end
                            else
                            begin
                                state_next = PS_DONE;
                            end
                        end

                        // Position value: blanks, digits up to 1000, blanks.
                        if (do_gdig && dg)
                        begin
                            dig_next = 1'b1;
                            if (gv_wide > POS_LIMIT)
                            begin
                                pos_next   = '0;
                                state_next = PS_DONE;
                            end
                            else
                            begin
                                pos_next   = gv_wide[POS_W-1:0];
                                state_next = PS_GDIG;
                            end
                        end
                        if (do_gtail)
                        begin
                            if (sp)
                            begin
                                state_next = PS_GTAIL;
                            end
                            else if ((c == CH_NUL) && dig_reg)
                            begin
                                cmd_next   = CMD_POSITION;
                                state_next = PS_DONE;
                            end
                            else
                            begin
                                pos_next   = '0;
                                state_next = PS_DONE;
                            end
                        end
                    end
                end
            endcase
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= PS_DONE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Working and result registers.
    always_ff @(posedge clk)
    begin
        cmd_reg   <= cmd_next;
        turn_reg  <= turn_next;
        pos_reg   <= pos_next;
        neg_reg   <= neg_next;
        dig_reg   <= dig_next;
        point_reg <= point_next;
        int_reg   <= int_next;
        frac_reg  <= frac_next;
        fcnt_reg  <= fcnt_next;
        mag_reg   <= mag_next;
    end

    assign res.done = (state_reg == PS_DONE);
    assign res.cmd  = cmd_reg;
    assign res.turn = turn_reg;
    assign res.pos  = pos_reg;

endmodule

// File: tb/tb.sv
// Self-checking bench for ascii_command_line_decoder_core: directed and random byte and tick
// requests, a timing-free model of the line decoder, and a scoreboard on the result channel.
// Depends on acld_pkg and the design files of the decoder.
module tb
    import acld_pkg::*;
();

    localparam int LINE_SLOTS   = LINE_CAPACITY_DEF - 1;
    localparam int DRAIN_CYCLES = 64;
    localparam int STUCK_LIMIT  = 2000;
    localparam int MAX_REPORTS  = 40;

    typedef struct packed {
        logic              is_tick;
        logic [CHAR_W-1:0] ch;
    } request_t;

    typedef struct packed {
        logic [CMD_W-1:0]         cmd;
        logic signed [TURN_W-1:0] turn;
        logic [POS_W-1:0]         pos;
    } cmd_result_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     in_valid = 1'b0;
    logic                     in_ready;
    logic                     req_type = 1'b0;
    logic [CHAR_W-1:0]        rx_byte = '0;
    logic                     out_valid;
    logic                     out_ready = 1'b0;
    logic [CMD_W-1:0]         cmd_type;
    logic signed [TURN_W-1:0] turn_target;
    logic [POS_W-1:0]         position_target;
    logic                     cfg_we = 1'b0;
    logic [TIMEOUT_W-1:0]     cfg_wdata = '0;

    ascii_command_line_decoder_core dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .req_type       (req_type),
        .rx_byte        (rx_byte),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .cmd_type       (cmd_type),
        .turn_target    (turn_target),
        .position_target(position_target),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Model state: stored line, its length, the idle tick counter and the timeout.
    logic [CHAR_W-1:0]    line_chars [0:LINE_SLOTS-1];
    int unsigned          line_len = 0;
    logic [TIMEOUT_W-1:0] idle_count = '0;
    logic [TIMEOUT_W-1:0] idle_limit = IDLE_TIMEOUT_RST;

    request_t    pending_requests[$];
    cmd_result_t expected_cmds[$];
    int unsigned mismatch_count = 0;
    int unsigned stim_count = 0;
    int unsigned stuck_cycles = 0;
    bit          sender_gaps_on = 1'b1;
    int unsigned send_wait;
    int unsigned send_calm;
    int unsigned recv_hold;
    int unsigned recv_calm;

    // Reads past the stored length behave as the end of the text.
    function automatic logic [CHAR_W-1:0] line_char(int unsigned p);
        if (p < line_len && p < LINE_SLOTS)
            return line_chars[p];
        return CH_NUL;
    endfunction

    function automatic bit blank_char(logic [CHAR_W-1:0] c);
        return (c == CH_SPACE) || (c == CH_TAB);
    endfunction

    function automatic bit decimal_char(logic [CHAR_W-1:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic [CMD_W-1:0] command_of(logic [CHAR_W-1:0] c);
        case (c | CASE_BIT)
            CH_LC_P: return CMD_START;
            CH_LC_S: return CMD_STOP;
            CH_LC_H: return CMD_HOME;
            CH_LC_C: return CMD_CLEAR;
            CH_LC_Q: return CMD_STATUS;
            CH_LC_Z: return CMD_ZERO;
            default: return CMD_INVALID;
        endcase
    endfunction

    // Signed decimal, in thousandths when it has a point; the integer part stops growing past 100000.
    function automatic bit parse_turn(int unsigned p, output logic [TURN_W-1:0] bits);
        logic [31:0]       whole;
        logic [31:0]       frac;
        logic [31:0]       scale;
        logic [31:0]       mag;
        logic [CHAR_W-1:0] c;
        bit                neg;
        bit                seen_digit;
        bit                seen_point;
        whole = 0;
        frac = 0;
        scale = 100;
        neg = 1'b0;
        seen_digit = 1'b0;
        seen_point = 1'b0;
        bits = '0;
        while (blank_char(line_char(p)))
            p++;
        c = line_char(p);
        if (c == CH_MINUS || c == CH_PLUS)
        begin
            neg = (c == CH_MINUS);
            p++;
        end
        while (decimal_char(line_char(p)))
        begin
            seen_digit = 1'b1;
            if (whole <= 32'd100000)
                whole = whole * 10 + (line_char(p) - CH_ZERO);
            p++;
        end
        if (line_char(p) == CH_POINT)
        begin
            seen_point = 1'b1;
            p++;
            while (decimal_char(line_char(p)))
            begin
                seen_digit = 1'b1;
                if (scale != 0)
                begin
                    frac = frac + (line_char(p) - CH_ZERO) * scale;
                    scale = scale / 10;
                end
                p++;
            end
        end
        while (blank_char(line_char(p)))
            p++;
        if (!seen_digit || line_char(p) != CH_NUL)
            return 1'b0;
        mag = seen_point ? whole * 1000 + frac : whole;
        if (neg)
            mag = -mag;
        bits = mag[TURN_W-1:0];
        return 1'b1;
    endfunction

    // Position 0 to 1000; any prefix above 1000 makes the line invalid.
    function automatic bit parse_position(int unsigned p, output logic [31:0] v);
        bit seen_digit;
        seen_digit = 1'b0;
        v = 0;
        while (blank_char(line_char(p)))
            p++;
        while (decimal_char(line_char(p)))
        begin
            seen_digit = 1'b1;
            v = v * 10 + (line_char(p) - CH_ZERO);
            if (v > 32'd1000)
                return 1'b0;
            p++;
        end
        while (blank_char(line_char(p)))
            p++;
        return seen_digit && line_char(p) == CH_NUL;
    endfunction

    function automatic cmd_result_t decode_line();
        cmd_result_t       r;
        int unsigned       p;
        logic [CHAR_W-1:0] c;
        logic [CMD_W-1:0]  code;
        logic [TURN_W-1:0] t;
        logic [31:0]       v;
        r = '0;
        r.cmd = CMD_INVALID;
        p = 0;
        while (blank_char(line_char(p)))
            p++;
        c = line_char(p);
        code = command_of(c);
        if (code != CMD_INVALID)
        begin
            // A single letter must stand alone.
            if (line_char(p + 1) == CH_NUL)
                r.cmd = code;
        end
        else if ((c | CASE_BIT) == CH_LC_T)
        begin
            if (parse_turn(p + 1, t))
            begin
                r.cmd = CMD_TURN;
                r.turn = t;
            end
        end
        else if ((c | CASE_BIT) == CH_LC_G)
        begin
            if (parse_position(p + 1, v))
            begin
                r.cmd = CMD_POSITION;
                r.pos = v[POS_W-1:0];
            end
        end
        return r;
    endfunction

    // Advances the model by one request; returns 1 when a command comes out.
    function automatic bit next_command(request_t req, output cmd_result_t r);
        logic [CMD_W-1:0] code;
        r = '0;
        if (req.is_tick)
        begin
            if (idle_count != TICKS_MAX)
                idle_count++;
            if (line_len != 0 && idle_count >= idle_limit)
            begin
                r = decode_line();
                line_len = 0;
                return 1'b1;
            end
            return 1'b0;
        end
        idle_count = '0;
        if (req.ch == CH_CR || req.ch == CH_LF)
        begin
            if (line_len == 0)
                return 1'b0;
            r = decode_line();
            line_len = 0;
            return 1'b1;
        end
        code = command_of(req.ch);
        if (line_len == 0 && code != CMD_INVALID)
        begin
            r.cmd = code;
            return 1'b1;
        end
        if (line_len < LINE_SLOTS)
        begin
            line_chars[line_len] = req.ch;
            line_len++;
            return 1'b0;
        end
        // One byte past a full line throws the line away.
        line_len = 0;
        r.cmd = CMD_INVALID;
        return 1'b1;
    endfunction

    // Idle length: mostly none or short, a few long, and now and then a calm stretch.
    function automatic int unsigned pick_gap(inout int unsigned calm);
        int unsigned r;
        if (calm != 0)
        begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 2)
        begin
            calm = $urandom_range(20, 60);
            return 0;
        end
        if (r < 60)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Request driver: feeds the queue onto the input channel and updates the model.
    always @(posedge clk or negedge rst_n)
    begin : driver
        request_t    cur;
        request_t    nxt;
        cmd_result_t res;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            req_type <= 1'b0;
            rx_byte <= '0;
            send_wait = 0;
            send_calm = 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                cur.is_tick = req_type;
                cur.ch = rx_byte;
                if (next_command(cur, res))
                    expected_cmds.push_back(res);
            end
            if (!in_valid || in_ready)
            begin
                if (send_wait != 0)
                begin
                    send_wait--;
                    in_valid <= 1'b0;
                end
                else if (pending_requests.size() != 0)
                begin
                    nxt = pending_requests.pop_front();
                    in_valid <= 1'b1;
                    req_type <= nxt.is_tick;
                    rx_byte <= nxt.ch;
                    send_wait = sender_gaps_on ? pick_gap(send_calm) : 0;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    task automatic report_field(string name, string want_s, string got_s);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("%0t: %s expected %s got %s", $time, name, want_s, got_s);
    endtask

    // Result monitor: compares each taken command with the oldest prediction.
    always @(posedge clk or negedge rst_n)
    begin : monitor
        cmd_result_t want;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            recv_hold = 0;
            recv_calm = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_cmds.size() == 0)
                    report_field("unexpected result", "none",
                        $sformatf("cmd %0d turn %0d pos %0d",
                            cmd_type, turn_target, position_target));
                else
                begin
                    want = expected_cmds.pop_front();
                    if (cmd_type !== want.cmd)
                        report_field("cmd_type", $sformatf("%0d", want.cmd),
                            $sformatf("%0d", cmd_type));
                    if (turn_target !== want.turn)
                        report_field("turn_target", $sformatf("%0d", want.turn),
                            $sformatf("%0d", turn_target));
                    if (position_target !== want.pos)
                        report_field("position_target", $sformatf("%0d", want.pos),
                            $sformatf("%0d", position_target));
                end
            end
            if (recv_hold != 0)
            begin
                recv_hold--;
                out_ready <= 1'b0;
            end
            else
            begin
                recv_hold = pick_gap(recv_calm);
                out_ready <= (recv_hold == 0);
            end
        end
    end

    // Watchdog: ends the run when nothing moves for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
                stuck_cycles <= 0;
            else
                stuck_cycles <= stuck_cycles + 1;
            if (stuck_cycles == STUCK_LIMIT)
            begin
                $display("%0t: no handshake for %0d cycles", $time, STUCK_LIMIT);
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    task automatic send_byte(logic [CHAR_W-1:0] b);
        pending_requests.push_back(request_t'{is_tick: 1'b0, ch: b});
        stim_count++;
    endtask

    // Ticks carry a random byte that the block must ignore.
    task automatic send_ticks(int unsigned n);
        repeat (n)
        begin
            pending_requests.push_back(request_t'{is_tick: 1'b1,
                ch: 8'($urandom_range(0, 255))});
            stim_count++;
        end
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    // A byte of a random line, now and then with ticks slipped in before it.
    task automatic send_char(logic [CHAR_W-1:0] b);
        if ($urandom_range(0, 99) < 2)
            send_ticks($urandom_range(1, 2));
        send_byte(b);
    endtask

    task automatic send_blanks(int unsigned most);
        repeat ($urandom_range(0, most))
            send_char($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
    endtask

    task automatic send_digits(int unsigned n);
        repeat (n)
            send_char(CH_ZERO + 8'($urandom_range(0, 9)));
    endtask

    function automatic logic [CHAR_W-1:0] any_case(logic [CHAR_W-1:0] c);
        return $urandom_range(0, 1) ? (c | CASE_BIT) : (c & ~CASE_BIT);
    endfunction

    function automatic logic [CHAR_W-1:0] pick_command_letter();
        case ($urandom_range(0, 5))
            0: return any_case(CH_LC_P);
            1: return any_case(CH_LC_S);
            2: return any_case(CH_LC_H);
            3: return any_case(CH_LC_C);
            4: return any_case(CH_LC_Q);
            default: return any_case(CH_LC_Z);
        endcase
    endfunction

    // Ends a line with CR, LF, or enough ticks to run out the idle timeout.
    task automatic close_line();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 20 && idle_limit <= 60)
            send_ticks((idle_limit == 0 ? 1 : idle_limit) + $urandom_range(0, 2));
        else if (r < 60)
            send_byte(CH_CR);
        else
            send_byte(CH_LF);
    endtask

    // One random line: mostly well-formed commands, the rest broken or noise.
    task automatic send_random_line();
        int unsigned kind;
        int unsigned r;
        kind = $urandom_range(0, 99);
        if (kind < 14)
            send_byte(pick_command_letter());
        else if (kind < 40)
        begin
            send_blanks(2);
            send_char(any_case(CH_LC_T));
            send_blanks(2);
            r = $urandom_range(0, 2);
            if (r == 1)
                send_char(CH_MINUS);
            else if (r == 2)
                send_char(CH_PLUS);
            send_digits($urandom_range(0, 3) == 0 ? $urandom_range(0, 9) : $urandom_range(1, 4));
            if ($urandom_range(0, 1))
            begin
                send_char(CH_POINT);
                send_digits($urandom_range(0, 5));
            end
            send_blanks(2);
            if ($urandom_range(0, 99) < 8)
                send_char(8'($urandom_range(33, 126)));
            close_line();
        end
        else if (kind < 60)
        begin
            send_blanks(2);
            send_char(any_case(CH_LC_G));
            send_blanks(2);
            r = $urandom_range(0, 99);
            if (r < 10)
                send_char(CH_ZERO);
            if (r < 75)
                send_text($sformatf("%0d", $urandom_range(0, 1000)));
            else if (r < 88)
                send_text($sformatf("%0d", $urandom_range(1001, 99999)));
            else
                send_digits($urandom_range(0, 5));
            send_blanks(2);
            if ($urandom_range(0, 99) < 5)
                send_char(8'($urandom_range(33, 126)));
            close_line();
        end
        else if (kind < 70)
        begin
            // A stored single letter, sometimes followed by stray text.
            send_char($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
            send_blanks(1);
            send_char(pick_command_letter());
            if ($urandom_range(0, 2) == 0)
                send_char(8'($urandom_range(32, 126)));
            close_line();
        end
        else if (kind < 80)
        begin
            repeat ($urandom_range(1, 36))
                send_char(8'($urandom_range(0, 255)));
            close_line();
        end
        else if (kind < 87)
        begin
            // A zero byte hides whatever follows it.
            send_char(any_case(CH_LC_G));
            send_digits($urandom_range(1, 3));
            send_char(CH_NUL);
            repeat ($urandom_range(1, 4))
                send_char(8'($urandom_range(1, 255)));
            close_line();
        end
        else if (kind < 92)
        begin
            // Lines around the buffer limit.
            repeat ($urandom_range(30, 33))
                send_byte(CH_ZERO + 8'($urandom_range(0, 9)));
            close_line();
        end
        else if (kind < 96)
        begin
            send_char(8'($urandom_range(33, 126)));
            send_digits($urandom_range(0, 3));
            close_line();
        end
        else
        begin
            send_ticks($urandom_range(1, 5));
            send_byte($urandom_range(0, 1) ? CH_CR : CH_LF);
        end
    endtask

    task automatic run_random(int unsigned count);
        stim_count = 0;
        while (stim_count < count)
            send_random_line();
    endtask

    // Waits until every request is taken and every command has come out, then drains.
    task automatic settle();
        while (pending_requests.size() != 0 || in_valid || expected_cmds.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_idle_limit(logic [TIMEOUT_W-1:0] v);
        settle();
        cfg_wdata <= v;
        cfg_we <= 1'b1;
        @(posedge clk);
        cfg_we <= 1'b0;
        idle_limit = v;
    endtask

    task automatic send_line(string s, logic [CHAR_W-1:0] term);
        send_text(s);
        send_byte(term);
    endtask

    initial
    begin : stimulus
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part with a short timeout.
        set_idle_limit(16'd4);
        send_text("pShCqZ");
        send_byte(CH_CR);
        send_ticks(2);
        send_line(" \tq", CH_CR);
        send_line(" s x", CH_LF);
        send_line("T1500", CH_LF);
        send_line("t -1.5 ", CH_CR);
        send_line("T+0.12345", CH_CR);
        send_line("T-9999999.9999", CH_LF);
        send_line("T.5", CH_CR);
        send_line("T.", CH_CR);
        send_line("G1000", CH_CR);
        send_line("g 0 ", CH_LF);
        send_line("G1001", CH_CR);
        send_line("X9", CH_CR);
        send_text("G12");
        send_byte(CH_NUL);
        send_line("zz", CH_CR);
        // Full line plus one byte, then an empty terminator.
        repeat (32) send_byte(CH_ZERO + 8'd1);
        send_byte(CH_CR);
        // Bytes restart the idle count; the timeout fires on ticks only.
        send_text("T7");
        send_ticks(3);
        send_byte(CH_ZERO + 8'd5);
        send_ticks(4);

        set_idle_limit(16'd1);
        run_random(80);
        set_idle_limit(16'd0);
        run_random(60);

        // Longest timeout: back-to-back ticks leave the line pending until CR.
        set_idle_limit(TICKS_MAX);
        sender_gaps_on = 1'b0;
        send_text("G7");
        send_ticks(40);
        send_byte(CH_CR);
        settle();
        sender_gaps_on = 1'b1;
        run_random(70);

        set_idle_limit(IDLE_TIMEOUT_RST);
        run_random(100);
        set_idle_limit(16'd9);
        run_random(100);

        settle();
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// File: filelist.f
design/acld_pkg.sv
design/acld_ram.sv
design/acld_parser.sv
design/ascii_command_line_decoder_core.sv
tb/tb.sv
